// ===== sv/modular_exponentiation_top_defines.svh =====
// Assertion macros used by the checker file of the modular exponentiation block.
`ifndef MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define MODULAR_EXPONENTIATION_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MME_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MME_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mme_pkg.sv =====
// Shared constants of the modular exponentiation block.
package mme_pkg;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd1;

endpackage

// ===== sv/modular_exponentiation_top.sv =====
// Top level of the modular exponentiation block: sequencer, registers and stream ports.
//
// Each input item carries a base in s_tdata and a last marker in s_tlast; the block
// returns base ^ exponent mod modulus in m_tdata with the marker copied to m_tlast.
// The exponent is scanned from its top bit down by binary square-and-multiply, and
// every modular product, including the initial reduction of the base, runs on one
// shared bit-serial multiplier. An item therefore runs 1 + WIDTH + popcount(exponent)
// products one after another, the reduction, a square per exponent bit and a
// multiply per set bit; a zero modulus gives 0 without the multiplier. s_tready
// is low while an item is at work. A finished result waits in the output register,
// so the next item is taken while the result is still unread; a second result waits
// for the first to be taken. Configuration writes (index 0 modulus, 1 exponent,
// others ignored) are always accepted and must only be made while the block is idle.
module modular_exponentiation_top #(
  parameter int WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  // Input items.
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [((WIDTH+7)/8)*8-1:0]   s_tdata,   // [WIDTH-1:0] base, zero padding above
  input  logic                         s_tlast,   // last_in
  // Result items.
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [((WIDTH+7)/8)*8-1:0]   m_tdata,   // [WIDTH-1:0] power_result, zero above
  output logic                         m_tlast,   // last_out
  // Configuration writes.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH-1:0]             cfg_data
);
  import mme_pkg::*;

  localparam int DW = ((WIDTH + 7) / 8) * 8;
  localparam int BW = $clog2(WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_FINISH
  } state_t;

  state_t           state;

  // Configuration registers.
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] exponent;

  // Working registers of the current item.
  logic [WIDTH-1:0] m_r;
  logic [WIDTH-1:0] e_r;
  logic [WIDTH-1:0] b_r;
  logic [WIDTH-1:0] r;
  logic [BW-1:0]    bit_idx;
  logic             last_r;

  // Multiplier request.
  logic             mm_start;
  logic [WIDTH-1:0] mm_x;
  logic [WIDTH-1:0] mm_y;
  logic             mm_done;
  logic [WIDTH-1:0] mm_res;

  logic             in_fire;
  logic             out_free;
  logic             last_bit;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign last_bit  = (bit_idx == '0);

  mme_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .x      (mm_x),
    .y      (mm_y),
    .m      (m_r),
    .done   (mm_done),
    .result (mm_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      modulus  <= WIDTH'(2);
      exponent <= WIDTH'(1);
      mm_start <= 1'b0;
      m_tvalid <= 1'b0;
      bit_idx  <= '0;
    end else begin
      mm_start <= 1'b0;

      // Write configuration; ignore unknown indexes.
      if (cfg_valid) begin
        case (cfg_index)
          REG_MODULUS:  modulus  <= cfg_data;
          REG_EXPONENT: exponent <= cfg_data;
          default: ;
        endcase
      end

      // Drop the result once it is taken, unless a new one is loaded now.
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            m_r    <= modulus;
            e_r    <= exponent;
            last_r <= s_tlast;
            if (modulus == '0) begin
              r     <= '0;
              state <= ST_FINISH;
            end else begin
              // Reduce the base: 1 * base mod m on the shared multiplier.
              mm_start <= 1'b1;
              mm_x     <= {{(WIDTH-1){1'b0}}, 1'b1};
              mm_y     <= s_tdata[WIDTH-1:0];
              state    <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (mm_done) begin
            b_r      <= mm_res;
            r        <= {{(WIDTH-1){1'b0}}, (m_r != WIDTH'(1))};
            bit_idx  <= BW'(WIDTH - 1);
            mm_start <= 1'b1;
            mm_x     <= {{(WIDTH-1){1'b0}}, (m_r != WIDTH'(1))};
            mm_y     <= {{(WIDTH-1){1'b0}}, (m_r != WIDTH'(1))};
            state    <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          if (mm_done) begin
            r <= mm_res;
            if (e_r[bit_idx]) begin
              mm_start <= 1'b1;
              mm_x     <= mm_res;
              mm_y     <= b_r;
              state    <= ST_MULT;
            end else if (last_bit) begin
              state <= ST_FINISH;
            end else begin
              bit_idx  <= bit_idx - 1'b1;
              mm_start <= 1'b1;
              mm_x     <= mm_res;
              mm_y     <= mm_res;
            end
          end
        end
        ST_MULT: begin
          if (mm_done) begin
            r <= mm_res;
            if (last_bit) begin
              state <= ST_FINISH;
            end else begin
              bit_idx  <= bit_idx - 1'b1;
              mm_start <= 1'b1;
              mm_x     <= mm_res;
              mm_y     <= mm_res;
              state    <= ST_SQUARE;
            end
          end
        end
        ST_FINISH: begin
          // Hold until the output register is free, then load the result.
          if (out_free) begin
            m_tdata  <= DW'(r);
            m_tlast  <= last_r;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/mme_mulmod.sv =====
// Bit-serial modular multiplier: one double-and-add step per cycle.
module mme_mulmod #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] result
);
  import mme_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic             run;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] xr;
  logic [WIDTH-1:0] yr;
  logic [WIDTH-1:0] mr;

  logic [WIDTH:0]   dbl;
  logic [WIDTH:0]   dred;
  logic [WIDTH:0]   sum;
  logic [WIDTH:0]   sred;
  logic [WIDTH-1:0] addend;
  logic [WIDTH-1:0] acc_next;

  // Double the accumulator, reduce, add x when the multiplier bit is set, reduce.
  always_comb begin
    dbl      = {acc, 1'b0};
    dred     = (dbl >= {1'b0, mr}) ? dbl - {1'b0, mr} : dbl;
    addend   = yr[WIDTH-1] ? xr : '0;
    sum      = dred + {1'b0, addend};
    sred     = (sum >= {1'b0, mr}) ? sum - {1'b0, mr} : sum;
    acc_next = sred[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(WIDTH);
        acc <= '0;
        xr  <= x;
        yr  <= y;
        mr  <= m;
      end else if (run) begin
        acc <= acc_next;
        yr  <= {yr[WIDTH-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = acc;

endmodule

// ===== sv/mme_checker.sv =====
// Port-level checker of the modular exponentiation block, bound to the top level.
`include "modular_exponentiation_top_defines.svh"

module mme_checker #(
  parameter int WIDTH = 32
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [((WIDTH+7)/8)*8-1:0] m_tdata,
  input logic                       m_tlast,
  input logic                       cfg_valid,
  input logic                       cfg_ready
);

  // A stalled result holds its value.
  `MME_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

  // An accepted item keeps the block busy in the next cycle.
  `MME_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "block ready right after accepting an item")

  // A new result appears only as the sequencer returns to idle.
  `MME_ASSERT_NOW(a_result_at_idle, clk, rst, $rose(m_tvalid), s_tready, "result shown while an item is still at work")

  // Configuration writes are never stalled.
  `MME_ASSERT_NOW(a_cfg_ready, clk, rst, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind modular_exponentiation_top mme_checker #(.WIDTH(WIDTH)) u_mme_checker (.*);

// ===== sim/modular_exponentiation_top_tb.sv =====
// Self-checking testbench for modular_exponentiation_top: directed and random stream traffic with a scoreboard.
module modular_exponentiation_top_tb;
  import mme_pkg::*;

  localparam int W      = 32;
  localparam int DATA_W = ((W + 7) / 8) * 8;

  // Indexes the block decodes to nothing; writes to them must leave both keys alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int RANDOM_ITEMS = 260;
  // Worst case per item is its busy time plus the longest sender gap and result stall;
  // the limit covers about 300 such items several times over.
  localparam int CYCLE_LIMIT  = 12_000_000;
  localparam int IDLE_CYCLES  = 8;
  localparam int TAIL_CYCLES  = 2500;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [W-1:0] base;
    logic         last;
    bit           drain_first;  // hold this item until every earlier result is back
  } block_t;

  typedef struct {
    logic [W-1:0] power;
    logic         last;
  } power_t;

  // DUT inputs start at known values.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata = '0;   // [W-1:0] base
  logic                  s_tlast = 1'b0; // last_in
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [DATA_W-1:0]     m_tdata;        // [W-1:0] power_result
  logic                  m_tlast;        // last_out
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [W-1:0]          cfg_data = '0;

  // Scoreboard copy of the two key registers, at their reset values.
  logic [W-1:0] key_modulus  = W'(2);
  logic [W-1:0] key_exponent = W'(1);

  block_t blocks_to_send[$];
  power_t powers_due[$];

  int  open_items = 0;     // queued blocks whose result has not come back yet
  int  errors = 0;
  int  blocks_sent = 0;
  int  results_checked = 0;
  int  reg_writes = 0;
  int  key_settings = 1;
  int  cycle_count = 0;
  bit  sender_gaps = 1'b0;
  bit  sink_stalls = 1'b0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;
  bit  presenting = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  run_left = 0;
  block_t on_bus;

  modular_exponentiation_top #(.WIDTH(W)) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Square-and-multiply over exact double-width products.
  function automatic logic [W-1:0] raise_mod(logic [W-1:0] b, logic [W-1:0] e,
                                             logic [W-1:0] n);
    logic [2*W-1:0] acc;
    logic [2*W-1:0] bb;
    logic [2*W-1:0] nn;
    if (n == '0) return '0;
    nn  = (2*W)'(n);
    bb  = (2*W)'(b) % nn;
    acc = (2*W)'(1) % nn;
    for (int i = W - 1; i >= 0; i--) begin
      acc = (acc * acc) % nn;
      if (e[i]) acc = (acc * bb) % nn;
    end
    return acc[W-1:0];
  endfunction

  // Mostly short pauses, now and then one long enough to span a whole item.
  function automatic int idle_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(300, 3000);
    return $urandom_range(0, 4);
  endfunction

  // Close a message every one to six blocks.
  function automatic logic next_last();
    if (run_left == 0) run_left = $urandom_range(1, 6);
    run_left--;
    return run_left == 0;
  endfunction

  function automatic logic [W-1:0] pick_modulus();
    logic [W-1:0] p;
    logic [W-1:0] q;
    case ($urandom_range(0, 7))
      0: return W'(2);
      1: return {W{1'b1}};
      2: return W'($urandom_range(2, 255));
      3: return W'($urandom_range(2, 65535));
      4, 5: begin
        // RSA-style modulus: product of two odd 16-bit factors.
        p = W'($urandom_range(3, 65535) | 1);
        q = W'($urandom_range(3, 65535) | 1);
        return p * q;
      end
      default: return W'($urandom_range(2, 32'hFFFF_FFFF));
    endcase
  endfunction

  function automatic logic [W-1:0] pick_exponent();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return W'(1);
      2: return W'(3);
      3: return W'(65537);
      4: return {W{1'b1}};
      5: return W'($urandom_range(0, 255));
      default: return W'($urandom);
    endcase
  endfunction

  function automatic logic [W-1:0] pick_base();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return W'(1);
      2: return key_modulus - 1;
      3: return key_modulus;
      4: return {W{1'b1}};
      5, 6: return (key_modulus > 1) ? W'($urandom_range(0, key_modulus - 1)) : '0;
      default: return W'($urandom);
    endcase
  endfunction

  task automatic send(logic [W-1:0] base, logic last, bit drain_first = 1'b0);
    blocks_to_send.push_back('{base, last, drain_first});
    open_items++;
    blocks_sent++;
  endtask

  // Block until every queued block has produced its result, then let the block settle.
  task automatic wait_idle();
    while (open_items > 0) @(negedge clk);
    repeat (IDLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODULUS:  key_modulus  = value;
      REG_EXPONENT: key_exponent = value;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sender: present one block at a time, with random gaps between blocks.
  always @(negedge clk) begin
    if (rst) begin
      presenting = 1'b0;
      gap_left   = 0;
    end else begin
      if (presenting && in_taken) begin
        presenting = 1'b0;
        gap_left   = sender_gaps ? idle_len() : 0;
      end
      if (!presenting) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (blocks_to_send.size() > 0 &&
                     (!blocks_to_send[0].drain_first || powers_due.size() == 0)) begin
          on_bus     = blocks_to_send.pop_front();
          presenting = 1'b1;
        end
      end
    end
    s_tvalid <= presenting;
    s_tdata  <= DATA_W'(on_bus.base);
    s_tlast  <= on_bus.last;
  end

  // Receiver: stall for a random while after each result, with short random drops.
  always @(negedge clk) begin
    logic ready_next;
    ready_next = 1'b1;
    if (rst) begin
      stall_left = 0;
    end else begin
      if (out_taken && sink_stalls) stall_left = idle_len();
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
        ready_next = 1'b0;
      end
    end
    m_tready <= ready_next;
  end

  // Scoreboard: predict on each accepted block, check each accepted result in order.
  always @(posedge clk) begin
    power_t want;
    in_taken  = !rst && s_tvalid && s_tready;
    out_taken = !rst && m_tvalid && m_tready;
    if (out_taken) begin
      open_items--;
      results_checked++;
      if (powers_due.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("ERROR: result %0h last %0b with nothing expected", m_tdata, m_tlast);
        errors++;
      end else begin
        want = powers_due.pop_front();
        if (m_tdata !== DATA_W'(want.power) || m_tlast !== want.last) begin
          if (errors < MAX_REPORTS)
            $display("ERROR: power %0h last %0b, expected power %0h last %0b",
                     m_tdata, m_tlast, want.power, want.last);
          errors++;
        end
      end
    end
    if (in_taken)
      powers_due.push_back('{raise_mod(s_tdata[W-1:0], key_exponent, key_modulus), s_tlast});
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results outstanding",
               cycle_count, open_items);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int random_sent;
    int count;
    int hold_at;
    random_sent = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset keys (modulus 2, exponent 1), extremes of the base.
    send(W'(0), 1'b0);
    send({W{1'b1}}, 1'b1);
    send(W'(3), 1'b1);

    // Both keys at their maximum; base equal to the modulus reduces to zero.
    wait_idle();
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    write_reg(REG_MODULUS, {W{1'b1}});
    write_reg(REG_EXPONENT, {W{1'b1}});
    key_settings++;
    send(W'(0), 1'b0);
    send(W'(1), 1'b0);
    send({W{1'b1}} - 1, 1'b0);
    send({W{1'b1}}, 1'b1, 1'b1);
    send(W'(32'h8000_0000), 1'b1);

    // Zero exponent gives one.
    wait_idle();
    write_reg(REG_EXPONENT, '0);
    write_reg(REG_MODULUS, W'(1000003));
    key_settings++;
    send(W'(12345), 1'b0);
    send(W'(0), 1'b1);

    // Modulus of one always gives zero.
    wait_idle();
    write_reg(REG_MODULUS, W'(1));
    write_reg(REG_EXPONENT, W'(65537));
    key_settings++;
    send(W'(0), 1'b1);
    send({W{1'b1}}, 1'b0);

    // Zero modulus lies outside the legal range: result zero, marker still copied.
    wait_idle();
    write_reg(REG_MODULUS, '0);
    key_settings++;
    send(W'(7), 1'b1);
    send({W{1'b1}}, 1'b0);

    // Writes to unused indexes must not disturb either key.
    wait_idle();
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    write_reg(REG_MODULUS, W'(2));
    write_reg(REG_EXPONENT, {W{1'b1}});
    write_reg(REG_SPARE_2, W'(32'h1234_5678));
    write_reg(REG_SPARE_3, W'(32'hFFFF_FFFF));
    key_settings++;
    send(W'(1), 1'b0);
    send(W'(2), 1'b0);
    send(W'(3), 1'b1);

    // Textbook RSA round trip: n = 61 * 53, encrypt 65 with e = 17, decrypt with d = 2753.
    wait_idle();
    write_reg(REG_MODULUS, W'(3233));
    write_reg(REG_EXPONENT, W'(17));
    key_settings++;
    send(W'(65), 1'b1);
    wait_idle();
    write_reg(REG_EXPONENT, W'(2753));
    key_settings++;
    send(W'(2790), 1'b1);

    // Random phases: fresh keys while idle, then a burst of blocks.
    while (random_sent < RANDOM_ITEMS) begin
      count = $urandom_range(6, 24);
      wait_idle();
      sender_gaps = $urandom_range(0, 3) != 0;
      sink_stalls = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 5) != 0) write_reg(REG_MODULUS, pick_modulus());
      if ($urandom_range(0, 5) != 0) write_reg(REG_EXPONENT, pick_exponent());
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, W'($urandom));
      key_settings++;
      hold_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, count - 1) : -1;
      for (int k = 0; k < count; k++)
        send(pick_base(), next_last(), k == hold_at);
      random_sent += count;
    end

    // Drain, then watch a while longer for stray results.
    while (open_items > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (powers_due.size() != 0) begin
      $display("ERROR: %0d results never arrived", powers_due.size());
      errors += powers_due.size();
    end

    $display("Raised %0d blocks under %0d key settings with %0d register writes;",
             blocks_sent, key_settings, reg_writes);
    $display("checked %0d results in %0d cycles, %0d errors.",
             results_checked, cycle_count, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
